// ----- rtl/fba_pkg.sv -----
// Shared types, codes and widths for the fixed block allocator.
`default_nettype none

package fba_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int EFFCNT_W   = $clog2(MAX_BLOCKS + 1);

  // Field and register widths.
  localparam int CMD_W    = 2;
  localparam int BB_W     = 13;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Derived datapath widths.
  localparam int SPAN_W = BB_W + EFFCNT_W;
  localparam int PROD_W = BB_W + IDX_W;
  localparam int DIV_W  = BB_W + IDX_W;
  localparam int DIV_STEPS = IDX_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0] POOL_BASE_RST   = 32'd0;
  localparam logic [BB_W-1:0]   BLOCK_BYTES_RST = 13'd16;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 7'd64;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BB_W-1:0]   request_bytes;
    logic [ADDR_W-1:0] address;
  } fba_in_t;

  // Result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
    logic                in_pool;
  } fba_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic eval;
    logic div_step;
    logic finish;
  } fba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free_cmd;
    logic out_room;
  } fba_sts_t;

endpackage

`default_nettype wire

// ----- rtl/fba_ctrl.sv -----
// Sequencing state machine of the fixed block allocator.
`default_nettype none

module fba_ctrl
  import fba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire fba_sts_t sts,
  output fba_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_EVAL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  // Commands follow the current state.
  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.prep     = (state == S_PREP);
    cmd.eval     = (state == S_EVAL);
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_FINISH) && sts.out_room;
  end

  assign in_stall = (state != S_IDLE);

  // State register and division step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          step <= '0;
          if (sts.is_free_cmd) begin
            state <= S_DIV;
          end else begin
            state <= S_FINISH;
          end
        end
        S_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts.out_room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The divider step counter stays below the step count while the divider runs.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (step < STEP_W'(DIV_STEPS)))
    else $error("divider step counter overran");

  // A result is never written into an occupied, stalled output register.
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_room)
    else $error("result written without room");

  // A taken item always starts processing; items are taken only while idle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_PREP))
    else $error("capture did not start processing");

endmodule

`default_nettype wire

// ----- rtl/fba_datapath.sv -----
// Datapath of the fixed block allocator: registers, free map, divider, result.
`default_nettype none

module fba_datapath
  import fba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fba_in_t              in_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire fba_cmd_t             cmd,
  output fba_sts_t                  sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output fba_out_t                  out_item
);

  // Configuration registers.
  logic [ADDR_W-1:0] pool_base;
  logic [BB_W-1:0]   block_bytes;
  logic [CNT_W-1:0]  block_count;

  // Allocation state: 1 marks a free block.
  logic [MAX_BLOCKS-1:0] free_map;

  // Captured item and intermediate values.
  fba_in_t             item;
  logic [SPAN_W-1:0]   span;
  logic [ADDR_W-1:0]   offset;
  logic                addr_ge;
  logic                in_pool;
  logic [IDX_W-1:0]    alloc_idx;
  logic                alloc_found;
  logic [PROD_W-1:0]   alloc_prod;

  // Divider registers.
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsor;
  logic [IDX_W-1:0] quot;

  // Combinational helpers.
  logic [BB_W-1:0]       eff_bb;
  logic [EFFCNT_W-1:0]   eff_cnt;
  logic [MAX_BLOCKS-1:0] avail;
  logic [IDX_W-1:0]      first_idx;
  logic                  first_found;
  fba_out_t              result;
  logic                  commit_alloc;
  logic                  commit_free;

  // A zero block size acts as one byte; the count saturates at the pool size.
  always_comb begin
    eff_bb  = (block_bytes == '0) ? BB_W'(1) : block_bytes;
    eff_cnt = (int'(block_count) > MAX_BLOCKS) ? EFFCNT_W'(MAX_BLOCKS)
                                               : EFFCNT_W'(block_count);
  end

  // Lowest free block among the blocks in use.
  always_comb begin
    first_found = 1'b0;
    first_idx   = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      avail[i] = free_map[i] && (i < int'(eff_cnt));
    end
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        first_found = 1'b1;
        first_idx   = IDX_W'(i);
      end
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= POOL_BASE_RST;
      block_bytes <= BLOCK_BYTES_RST;
      block_count <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_BASE:   pool_base   <= cfg_data[ADDR_W-1:0];
        REG_BLOCK_BYTES: block_bytes <= cfg_data[BB_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item capture, geometry and search stage, then the evaluation stage.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
    if (cmd.prep) begin
      span        <= SPAN_W'(eff_bb) * SPAN_W'(eff_cnt);
      offset      <= item.address - pool_base;
      addr_ge     <= (item.address >= pool_base);
      alloc_idx   <= first_idx;
      alloc_found <= first_found;
    end
    if (cmd.eval) begin
      in_pool    <= addr_ge && (ADDR_W'(span) > offset);
      alloc_prod <= PROD_W'(eff_bb) * PROD_W'(alloc_idx);
    end
  end

  // Restoring divider: one quotient bit per step, largest first.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rem  <= offset[DIV_W-1:0];
      dsor <= DIV_W'({eff_bb, {(IDX_W - 1){1'b0}}});
      quot <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dsor) begin
        rem  <= rem - dsor;
        quot <= {quot[IDX_W-2:0], 1'b1};
      end else begin
        quot <= {quot[IDX_W-2:0], 1'b0};
      end
      dsor <= dsor >> 1;
    end
  end

  // Result and free map update for the finished item.
  always_comb begin
    result       = '0;
    commit_alloc = 1'b0;
    commit_free  = 1'b0;
    unique case (item.cmd)
      CMD_ALLOC: begin
        if (item.request_bytes > eff_bb) begin
          result.status = ST_TOO_LARGE;
        end else if (alloc_found) begin
          result.status        = ST_OK;
          result.block_address = pool_base + ADDR_W'(alloc_prod);
          commit_alloc         = 1'b1;
        end else begin
          result.status = ST_NO_FREE;
        end
      end
      CMD_FREE: begin
        result.in_pool = in_pool;
        if (!in_pool) begin
          result.status = ST_OUTSIDE;
        end else if (rem != '0) begin
          result.status = ST_MISALIGNED;
        end else if (free_map[quot]) begin
          result.status = ST_NOT_IN_USE;
        end else begin
          result.status = ST_OK;
          commit_free   = 1'b1;
        end
      end
      CMD_CONTAINS: begin
        result.in_pool = in_pool;
      end
      default: begin
      end
    endcase
  end

  // Free map: all blocks free after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else if (cmd.finish) begin
      if (commit_alloc) begin
        free_map[alloc_idx] <= 1'b0;
      end else if (commit_free) begin
        free_map[quot] <= 1'b1;
      end
    end
  end

  // Output register; a waiting result does not block the input side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item <= result;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.is_free_cmd = (item.cmd == CMD_FREE);
    sts.out_room    = !out_valid || !out_stall;
  end

  // A successful allocate takes exactly one block.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && commit_alloc) |=>
      ($countones(free_map) == $past($countones(free_map)) - 1))
    else $error("allocate did not take exactly one block");

  // A successful free returns exactly one block.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && commit_free) |=>
      ($countones(free_map) == $past($countones(free_map)) + 1))
    else $error("free did not return exactly one block");

  // A finished item always shows up on the output.
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item not presented");

endmodule

`default_nettype wire

// ----- rtl/fixed_block_allocator_core.sv -----
// Top level of the fixed block allocator: controller plus datapath.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall   in_item (fba_in_t)
//   out       output     out_valid / out_stall out_item (fba_out_t)
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// Allocate and contains items pass the prepare, evaluate and finish states;
// a free item also passes the divide state, where a restoring divider divides
// the offset by the block size, one quotient bit per cycle (6 steps).
// Reset is synchronous; it restores the register defaults and marks every
// block free in the same cycle, with no clearing pass.
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled output holds the following item at its final step.
`default_nettype none

module fixed_block_allocator_core
  import fba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire fba_in_t              in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output fba_out_t                  out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  fba_cmd_t cmd;
  fba_sts_t sts;

  // Sequencer.
  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, free map, divider and result path.
  fba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
